[src/dual_vca_soft_clip_defines.svh]
// ----------------------------------------------------------------------------
// dual_vca_soft_clip_defines
// Assertion macros used by the dual VCA top module.
// ----------------------------------------------------------------------------
`ifndef DUAL_VCA_SOFT_CLIP_DEFINES_SVH
`define DUAL_VCA_SOFT_CLIP_DEFINES_SVH

// same-cycle implication
`define DVSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvsc: same-cycle check failed");

// next-cycle implication
`define DVSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvsc: next-cycle check failed");

`endif

[src/dvsc_pkg.sv]
// ----------------------------------------------------------------------------
// dvsc_pkg
// Types and constants of the dual VCA with soft clip.
// ----------------------------------------------------------------------------
package dvsc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 17;
    localparam int ADDR_W   = 5;
    localparam int CV_SHIFT = SAMPLE_W - 2;
    localparam int TEN_V    = 2 ** CV_SHIFT;
    localparam int UNITY    = 65536;

    typedef enum logic [2:0] {
        REG_FIRST_GAIN  = 3'd0,
        REG_SECOND_GAIN = 3'd1,
        REG_EXP_MODE    = 3'd2,
        REG_SOFT_CLIP   = 3'd3,
        REG_SUM_MODE    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_audio;
        logic signed [SAMPLE_W-1:0] first_cv;
        logic                       first_cv_present;
        logic signed [SAMPLE_W-1:0] second_audio;
        logic signed [SAMPLE_W-1:0] second_cv;
        logic                       second_cv_present;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_out;
        logic signed [SAMPLE_W-1:0] second_out;
        logic [GAIN_W-1:0]          first_applied_gain;
        logic [GAIN_W-1:0]          second_applied_gain;
    } t_out_word;

    typedef struct packed {
        logic s4;
        logic s5;
    } t_clip_en;

endpackage

[src/dual_vca_soft_clip.sv]
// ----------------------------------------------------------------------------
// dual_vca_soft_clip
// Two-channel VCA: knob/CV gain (optionally summed), clamp, optional square law, optional tanh clip.
// ----------------------------------------------------------------------------
//  port group     | direction | handshake
//  i_in_word      | in        | i_in_valid / o_in_stall
//  o_out_word     | out       | o_out_valid / i_out_stall
//  APB registers  | in/out    | psel, penable, pwrite, pready (always 1)
//
//  Five-stage pipeline, one word per cycle while the output is not stalled.
//  Stages: CV multiply, gain clamp + square, audio multiply, round/saturate
//  + table lookup, interpolation. The multipliers set the stage depth.
//  A stage holds only while it and all later stages are full and the output
//  is stalled; bubbles close up.
//  Synchronous active-low reset clears valid bits and sets gains to unity, modes off.
// ----------------------------------------------------------------------------
`include "dual_vca_soft_clip_defines.svh"

module dual_vca_soft_clip #(
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dvsc_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dvsc_pkg::t_out_word           o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dvsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SW = dvsc_pkg::SAMPLE_W;
    localparam int GW = dvsc_pkg::GAIN_W;
    localparam int KW = GW + 1;
    localparam int PW = KW + SW + 2;
    localparam int QW = 2 * GW;
    localparam int AW = SW + KW;

    // configuration registers
    logic [GW-1:0] r_first_gain;
    logic [GW-1:0] r_second_gain;
    logic          r_exp_mode;
    logic          r_soft_clip;
    logic          r_sum_mode;
    logic          w_cfg_wr;
    dvsc_pkg::t_reg_idx w_reg;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg    = dvsc_pkg::t_reg_idx'(paddr[dvsc_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_gain  <= GW'(dvsc_pkg::UNITY);
            r_second_gain <= GW'(dvsc_pkg::UNITY);
            r_exp_mode    <= 1'b0;
            r_soft_clip   <= 1'b0;
            r_sum_mode    <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                dvsc_pkg::REG_FIRST_GAIN:  r_first_gain  <= pwdata[GW-1:0];
                dvsc_pkg::REG_SECOND_GAIN: r_second_gain <= pwdata[GW-1:0];
                dvsc_pkg::REG_EXP_MODE:    r_exp_mode    <= pwdata[0];
                dvsc_pkg::REG_SOFT_CLIP:   r_soft_clip   <= pwdata[0];
                dvsc_pkg::REG_SUM_MODE:    r_sum_mode    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            dvsc_pkg::REG_FIRST_GAIN:  prdata = 32'(r_first_gain);
            dvsc_pkg::REG_SECOND_GAIN: prdata = 32'(r_second_gain);
            dvsc_pkg::REG_EXP_MODE:    prdata = 32'(r_exp_mode);
            dvsc_pkg::REG_SOFT_CLIP:   prdata = 32'(r_soft_clip);
            dvsc_pkg::REG_SUM_MODE:    prdata = 32'(r_sum_mode);
            default:                   prdata = 32'd0;
        endcase
    end

    // stage enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5      = !r_v5 || !i_out_stall;
    assign w_en4      = !r_v4 || w_en5;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // stage 1: operand select and CV multiply
    logic [KW-1:0]        w_ks;
    logic signed [SW:0]   w_cvs;
    logic [SW-2:0]        w_cvc;
    logic                 w_any;
    logic signed [KW:0]   w_ma1, w_ma2;
    logic signed [SW:0]   w_mb1, w_mb2;
    logic [KW-1:0]        w_kn1, w_kn2;
    logic                 w_use1, w_use2;

    assign w_ks  = KW'(r_first_gain) + KW'(r_second_gain);
    assign w_any = i_in_word.first_cv_present || i_in_word.second_cv_present;
    assign w_cvs = (i_in_word.first_cv_present  ? (SW+1)'(i_in_word.first_cv)  : '0)
                 + (i_in_word.second_cv_present ? (SW+1)'(i_in_word.second_cv) : '0);

    always_comb begin
        if (w_cvs < 0) begin
            w_cvc = '0;
        end else if (w_cvs > (SW+1)'(dvsc_pkg::TEN_V)) begin
            w_cvc = (SW-1)'(dvsc_pkg::TEN_V);
        end else begin
            w_cvc = w_cvs[SW-2:0];
        end
    end

    always_comb begin
        if (r_sum_mode) begin
            w_ma1  = {1'b0, w_ks};
            w_mb1  = {2'b00, w_cvc};
            w_kn1  = w_ks;
            w_use1 = !w_any;
            w_ma2  = w_ma1;
            w_mb2  = w_mb1;
            w_kn2  = w_ks;
            w_use2 = !w_any;
        end else begin
            w_ma1  = {2'b00, r_first_gain};
            w_mb1  = (SW+1)'(i_in_word.first_cv);
            w_kn1  = KW'(r_first_gain);
            w_use1 = !i_in_word.first_cv_present;
            w_ma2  = {2'b00, r_second_gain};
            w_mb2  = (SW+1)'(i_in_word.second_cv);
            w_kn2  = KW'(r_second_gain);
            w_use2 = !i_in_word.second_cv_present;
        end
    end

    logic signed [PW-1:0] r1_p1, r1_p2;
    logic [KW-1:0]        r1_k1, r1_k2;
    logic                 r1_u1, r1_u2;
    logic signed [SW-1:0] r1_a1, r1_a2;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_p1 <= w_ma1 * w_mb1;
            r1_p2 <= w_ma2 * w_mb2;
            r1_k1 <= w_kn1;
            r1_k2 <= w_kn2;
            r1_u1 <= w_use1;
            r1_u2 <= w_use2;
            r1_a1 <= i_in_word.first_audio;
            r1_a2 <= i_in_word.second_audio;
        end
    end

    // stage 2: clamp and square
    function automatic logic [GW-1:0] clamp_gain(
        input logic signed [PW-1:0] p,
        input logic [KW-1:0]        k,
        input logic                 use_knob
    );
        logic [PW-dvsc_pkg::CV_SHIFT-1:0] sh;
        sh = p[PW-1:dvsc_pkg::CV_SHIFT];
        if (use_knob) begin
            return (k > KW'(dvsc_pkg::UNITY)) ? GW'(dvsc_pkg::UNITY) : k[GW-1:0];
        end else if (p <= 0) begin
            return '0;
        end else if (sh > (PW-dvsc_pkg::CV_SHIFT)'(dvsc_pkg::UNITY)) begin
            return GW'(dvsc_pkg::UNITY);
        end
        return sh[GW-1:0];
    endfunction

    logic [GW-1:0]        w_g1c, w_g2c;
    logic [GW-1:0]        r2_g1, r2_g2;
    logic [QW-1:0]        r2_q1, r2_q2;
    logic signed [SW-1:0] r2_a1, r2_a2;

    assign w_g1c = clamp_gain(r1_p1, r1_k1, r1_u1);
    assign w_g2c = clamp_gain(r1_p2, r1_k2, r1_u2);

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_g1 <= w_g1c;
            r2_g2 <= w_g2c;
            r2_q1 <= QW'(w_g1c) * QW'(w_g1c);
            r2_q2 <= QW'(w_g2c) * QW'(w_g2c);
            r2_a1 <= r1_a1;
            r2_a2 <= r1_a2;
        end
    end

    // stage 3: curve select and audio multiply
    logic [GW-1:0]        w_g1, w_g2;
    logic [QW-1:0]        w_q1r, w_q2r;
    logic signed [KW-1:0] w_gs1, w_gs2;

    assign w_q1r = r2_q1 + QW'(32768);
    assign w_q2r = r2_q2 + QW'(32768);
    assign w_g1  = r_exp_mode ? w_q1r[GW+15:16] : r2_g1;
    assign w_g2  = r_exp_mode ? w_q2r[GW+15:16] : r2_g2;
    assign w_gs1 = {1'b0, w_g1};
    assign w_gs2 = {1'b0, w_g2};

    logic signed [AW-1:0] r3_x1, r3_x2;
    logic [GW-1:0]        r3_g1, r3_g2;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_x1 <= r2_a1 * w_gs1;
            r3_x2 <= r2_a2 * w_gs2;
            r3_g1 <= w_g1;
            r3_g2 <= w_g2;
        end
    end

    // stage 4: round half up, saturate, then clip unit
    function automatic logic signed [SW-1:0] round_sat(input logic signed [AW-1:0] p);
        logic signed [AW:0]    r;
        logic signed [AW-16:0] q;
        r = (AW+1)'(p) + (AW+1)'(32768);
        q = r[AW:16];
        if (q > (AW-15)'((2 ** (SW - 1)) - 1)) begin
            return {1'b0, {(SW-1){1'b1}}};
        end else if (q < -(AW-15)'(2 ** (SW - 1))) begin
            return {1'b1, {(SW-1){1'b0}}};
        end
        return q[SW-1:0];
    endfunction

    dvsc_pkg::t_clip_en   w_clip_en;
    logic signed [SW-1:0] w_y1, w_y2;
    logic [GW-1:0]        r4_g1, r4_g2;
    logic [GW-1:0]        r5_g1, r5_g2;

    assign w_clip_en.s4 = w_en4;
    assign w_clip_en.s5 = w_en5;

    dvsc_clip #(
        .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
    ) u_clip1 (
        .i_clk  (i_clk),
        .i_en   (w_clip_en),
        .i_soft (r_soft_clip),
        .i_x    (round_sat(r3_x1)),
        .o_y    (w_y1)
    );

    dvsc_clip #(
        .TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
    ) u_clip2 (
        .i_clk  (i_clk),
        .i_en   (w_clip_en),
        .i_soft (r_soft_clip),
        .i_x    (round_sat(r3_x2)),
        .o_y    (w_y2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_g1 <= r3_g1;
            r4_g2 <= r3_g2;
        end
        if (w_en5) begin
            r5_g1 <= r4_g1;
            r5_g2 <= r4_g2;
        end
    end

    assign o_out_valid                    = r_v5;
    assign o_out_word.first_out           = w_y1;
    assign o_out_word.second_out          = w_y2;
    assign o_out_word.first_applied_gain  = r5_g1;
    assign o_out_word.second_applied_gain = r5_g2;

    `DVSC_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_in_stall,
        r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_out_stall)
    `DVSC_ASSERT_NXT(a_accept_loads, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_v1)
    `DVSC_ASSERT_IMP(a_gain_bound, i_clk, i_rst_n, o_out_valid,
        (o_out_word.first_applied_gain <= GW'(dvsc_pkg::UNITY))
        && (o_out_word.second_applied_gain <= GW'(dvsc_pkg::UNITY)))
    `DVSC_ASSERT_NXT(a_drain, i_clk, i_rst_n, r_v5 && !i_out_stall && !r_v4, !r_v5)

endmodule

[src/dvsc_clip.sv]
// ----------------------------------------------------------------------------
// dvsc_clip
// Two-stage soft clipper: 10 V * tanh(x / 10 V) by interpolated constant table, or bypass.
// ----------------------------------------------------------------------------
module dvsc_clip #(
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  dvsc_pkg::t_clip_en                   i_en,
    input  logic                                 i_soft,
    input  logic signed [dvsc_pkg::SAMPLE_W-1:0] i_x,
    output logic signed [dvsc_pkg::SAMPLE_W-1:0] o_y
);

    localparam int SW = dvsc_pkg::SAMPLE_W;
    localparam int SH = SW - 1;
    localparam int TW = SW - 1;
    localparam int LW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int PW = LW + SW;
    localparam int MW = 2 * SH + 1;

    // elaboration-time long division for the table build
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [TW-1:0] tanh_entry(input int unsigned idx);
        logic [63:0] v;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        v    = udiv64(64'(idx) << 26, 64'(TANH_TABLE_DEPTH));
        term = 64'd1 << 24;
        e    = 64'd1 << 24;
        for (int k = 1; k < 80; k++) begin
            if (term != 64'd0) begin
                term = udiv64((term * v) >> 24, 64'(k));
                e    = e + term;
            end
        end
        num = (e - (64'd1 << 24)) * 64'd2 * 64'(dvsc_pkg::TEN_V);
        den = 64'd2 * (e + (64'd1 << 24));
        return TW'(udiv64(num + (e + (64'd1 << 24)), den));
    endfunction

    logic [TW-1:0] w_lut [TANH_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= TANH_TABLE_DEPTH; gi++) begin : g_lut
        localparam logic [TW-1:0] Entry = tanh_entry(gi);
        assign w_lut[gi] = Entry;
    end

    // stage 4: table index and fraction
    logic          w_neg;
    logic [SW-1:0] w_abs;
    logic [PW-1:0] w_pos;
    logic [LW-1:0] w_idx_raw;
    logic [LW-1:0] w_idx;
    logic [LW-1:0] w_idx1;
    logic [SH:0]   w_frac;
    logic [TW-1:0] w_t0;
    logic [TW-1:0] w_t1;

    assign w_neg     = i_x[SW-1];
    assign w_abs     = w_neg ? (~i_x + SW'(1)) : i_x;
    assign w_pos     = PW'(w_abs) * PW'(TANH_TABLE_DEPTH);
    assign w_idx_raw = w_pos[SH+LW-1:SH];

    always_comb begin
        if (w_idx_raw >= LW'(TANH_TABLE_DEPTH)) begin
            w_idx  = LW'(TANH_TABLE_DEPTH - 1);
            w_frac = (SH+1)'(1) << SH;
        end else begin
            w_idx  = w_idx_raw;
            w_frac = {1'b0, w_pos[SH-1:0]};
        end
    end

    assign w_idx1 = w_idx + LW'(1);
    assign w_t0   = w_lut[w_idx];
    assign w_t1   = w_lut[w_idx1];

    logic [TW-1:0]        r_t0;
    logic [TW-1:0]        r_d;
    logic [SH:0]          r_f;
    logic                 r_neg;
    logic                 r_soft;
    logic signed [SW-1:0] r_x;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_t0   <= w_t0;
            r_d    <= w_t1 - w_t0;
            r_f    <= w_frac;
            r_neg  <= w_neg;
            r_soft <= i_soft;
            r_x    <= i_x;
        end
    end

    // stage 5: interpolate and restore sign
    logic [MW-1:0] w_mix;
    logic [SW-1:0] w_mag;
    logic [SW-1:0] n_y;

    assign w_mix = MW'(r_d) * MW'(r_f) + (MW'(1) << (SH - 1));
    assign w_mag = SW'(r_t0) + w_mix[SH+SW-1:SH];

    always_comb begin
        if (!r_soft) begin
            n_y = r_x;
        end else if (r_neg) begin
            n_y = ~w_mag + SW'(1);
        end else begin
            n_y = w_mag;
        end
    end

    logic signed [SW-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule
